FILE: hdl/mfpm_pkg.sv
`timescale 1ns / 1ps
package mfpm_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int SAMPLE_W   = 8;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int FC_W       = 4;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  // register index, taken from paddr[ADDR_W-1:2]
  localparam logic REG_FRAME_COUNT = 1'b0;

  localparam logic [FC_W-1:0] FRAME_COUNT_RESET = FC_W'(1);

  typedef enum logic [0:0] {
    ST_EMPTY,
    ST_GATHER
  } ctrl_state_t;

  typedef struct packed {
    logic             insert;
    logic             emit;
    logic [CNT_W-1:0] held;
    logic [IDX_W-1:0] mid;
  } dp_cmd_t;

endpackage

FILE: hdl/multi_frame_pixel_median.sv
`timescale 1ns / 1ps
// channel   direction  signals                              transfer when
// input     in         start, busy, sample[7:0]             start && !busy
// result    out        valid, median_value[7:0]             valid (one cycle)
// config    in/out     psel, penable, pwrite, paddr[2:0],   psel && penable && pwrite
//                      pwdata, prdata, pready
//
// One sample is inserted into the sorted row each cycle; busy stays low.
// The median is registered and appears in the cycle after the sample that completes a position.
// Synchronous reset empties the row and sets frame_count to 1.
// The receiver cannot stall; each result is shown for one cycle only.
module multi_frame_pixel_median (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [mfpm_pkg::SAMPLE_W-1:0]     sample,
  output logic                              valid,
  output logic [mfpm_pkg::SAMPLE_W-1:0]     median_value,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mfpm_pkg::ADDR_W-1:0]       paddr,
  input  logic [mfpm_pkg::DATA_W-1:0]       pwdata,
  output logic [mfpm_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  logic [mfpm_pkg::FC_W-1:0] frame_count;
  logic                      fc_write;
  logic                      accept;
  mfpm_pkg::dp_cmd_t         cmd;

  // insertion completes within the cycle, so a new sample is always taken
  assign busy   = 1'b0;
  assign accept = start && !busy;

  mfpm_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .frame_count (frame_count),
    .fc_write    (fc_write)
  );

  mfpm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .fc_write    (fc_write),
    .frame_count (frame_count),
    .cmd         (cmd)
  );

  mfpm_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample       (sample),
    .median_value (median_value),
    .valid        (valid)
  );

endmodule

FILE: hdl/mfpm_regs.sv
`timescale 1ns / 1ps
module mfpm_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mfpm_pkg::ADDR_W-1:0]       paddr,
  input  logic [mfpm_pkg::DATA_W-1:0]       pwdata,
  output logic [mfpm_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  output logic [mfpm_pkg::FC_W-1:0]         frame_count,
  output logic                              fc_write
);

  logic hit;

  assign pready   = 1'b1;
  assign hit      = (paddr[mfpm_pkg::ADDR_W-1:2] == mfpm_pkg::REG_FRAME_COUNT);
  assign fc_write = psel && penable && pwrite && pready && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= mfpm_pkg::FRAME_COUNT_RESET;
    end else if (fc_write) begin
      frame_count <= pwdata[mfpm_pkg::FC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(mfpm_pkg::DATA_W - mfpm_pkg::FC_W){1'b0}}, frame_count};
    end
  end

endmodule

FILE: hdl/mfpm_ctrl.sv
`timescale 1ns / 1ps
module mfpm_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          fc_write,
  input  logic [mfpm_pkg::FC_W-1:0]     frame_count,
  output mfpm_pkg::dp_cmd_t             cmd
);

  mfpm_pkg::ctrl_state_t state, state_next;
  logic [mfpm_pkg::CNT_W-1:0] held, held_next;
  logic [mfpm_pkg::CNT_W-1:0] held_cur;
  logic [mfpm_pkg::CNT_W-1:0] n_eff;
  logic [mfpm_pkg::CNT_W-1:0] held_inc;

  // zero means one frame, anything beyond the store saturates
  always_comb begin
    if (frame_count == '0) begin
      n_eff = mfpm_pkg::CNT_W'(1);
    end else if (mfpm_pkg::CNT_W'(frame_count) > mfpm_pkg::CNT_W'(mfpm_pkg::MAX_FRAMES)) begin
      n_eff = mfpm_pkg::CNT_W'(mfpm_pkg::MAX_FRAMES);
    end else begin
      n_eff = mfpm_pkg::CNT_W'(frame_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfpm_pkg::ST_EMPTY;
      held  <= '0;
    end else begin
      state <= state_next;
      held  <= held_next;
    end
  end

  always_comb begin
    case (state)
      mfpm_pkg::ST_EMPTY:  held_cur = '0;
      mfpm_pkg::ST_GATHER: held_cur = (held >= mfpm_pkg::CNT_W'(mfpm_pkg::MAX_FRAMES)) ?
                                      '0 : held;
      default:             held_cur = '0;
    endcase
    held_inc   = held_cur + mfpm_pkg::CNT_W'(1);

    cmd.insert = accept;
    cmd.held   = held_cur;
    cmd.emit   = accept && (held_inc >= n_eff);
    cmd.mid    = mfpm_pkg::IDX_W'(n_eff >> 1);

    state_next = state;
    held_next  = held;
    if (fc_write) begin
      // drop a partly gathered position
      state_next = mfpm_pkg::ST_EMPTY;
      held_next  = '0;
    end else if (accept) begin
      if (cmd.emit) begin
        state_next = mfpm_pkg::ST_EMPTY;
        held_next  = '0;
      end else begin
        state_next = mfpm_pkg::ST_GATHER;
        held_next  = held_inc;
      end
    end
  end

endmodule

FILE: hdl/mfpm_dpath.sv
`timescale 1ns / 1ps
module mfpm_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  mfpm_pkg::dp_cmd_t                cmd,
  input  logic [mfpm_pkg::SAMPLE_W-1:0]    sample,
  output logic [mfpm_pkg::SAMPLE_W-1:0]    median_value,
  output logic                             valid
);

  logic [mfpm_pkg::SAMPLE_W-1:0] entry      [mfpm_pkg::MAX_FRAMES];
  logic [mfpm_pkg::SAMPLE_W-1:0] entry_next [mfpm_pkg::MAX_FRAMES];
  logic [mfpm_pkg::MAX_FRAMES-1:0] live;
  logic [mfpm_pkg::MAX_FRAMES-1:0] greater;

  // each slot either keeps its value, takes its lower neighbor, or takes the sample
  always_comb begin
    for (int i = 0; i < mfpm_pkg::MAX_FRAMES; i++) begin
      live[i]    = (mfpm_pkg::CNT_W'(i) < cmd.held);
      greater[i] = live[i] && (entry[i] > sample);
    end
    for (int i = 0; i < mfpm_pkg::MAX_FRAMES; i++) begin
      if (live[i] && !greater[i]) begin
        entry_next[i] = entry[i];
      end else if (i > 0 && greater[(i > 0) ? i - 1 : 0]) begin
        entry_next[i] = entry[(i > 0) ? i - 1 : 0];
      end else begin
        entry_next[i] = sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < mfpm_pkg::MAX_FRAMES; i++) begin
        entry[i] <= entry_next[i];
      end
    end
    if (cmd.emit) begin
      median_value <= entry_next[cmd.mid];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
  end

endmodule

FILE: bench/mfpm_checker.sv
`timescale 1ns / 1ps
module mfpm_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [mfpm_pkg::SAMPLE_W-1:0]     sample,
  input  logic                              valid,
  input  logic [mfpm_pkg::SAMPLE_W-1:0]     median_value,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mfpm_pkg::ADDR_W-1:0]       paddr,
  input  logic [mfpm_pkg::DATA_W-1:0]       pwdata,
  input  logic [mfpm_pkg::DATA_W-1:0]       prdata,
  input  logic                              pready,
  output int                                mismatches,
  output int                                pending,
  output int                                medians_checked
);
  import mfpm_pkg::*;

  logic [SAMPLE_W-1:0] row [MAX_FRAMES];
  int                  held;
  logic [FC_W-1:0]     fc_reg;
  logic [SAMPLE_W-1:0] pending_medians [$];
  int                  err_count;
  int                  done_count;

  task automatic flag_mismatch(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Insert one sample into the sorted row; return 1 when it closes a position.
  function automatic bit insert_sample(input logic [SAMPLE_W-1:0] s,
                                       output logic [SAMPLE_W-1:0] med);
    int frames;
    int pos;
    frames = fc_reg;
    if (frames == 0) frames = 1;
    if (frames > MAX_FRAMES) frames = MAX_FRAMES;
    if (held >= MAX_FRAMES) held = 0;
    pos = held;
    while (pos > 0 && row[pos-1] > s) begin
      row[pos] = row[pos-1];
      pos--;
    end
    row[pos] = s;
    held++;
    if (held >= frames) begin
      med  = row[frames/2];
      held = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    logic [SAMPLE_W-1:0] med;
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      held   = 0;
      fc_reg = FRAME_COUNT_RESET;
      pending_medians.delete();
    end else begin
      if (valid) begin
        if (pending_medians.size() == 0) begin
          flag_mismatch($sformatf("median %0d with nothing outstanding", median_value));
        end else begin
          want = pending_medians.pop_front();
          done_count++;
          if (median_value !== want)
            flag_mismatch($sformatf("median_value %0d, predicted %0d", median_value, want));
        end
      end
      if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_FRAME_COUNT) begin
        if (pwrite) begin
          // a write drops whatever was gathered for the open position
          fc_reg = pwdata[FC_W-1:0];
          held   = 0;
        end else if (prdata[FC_W-1:0] !== fc_reg) begin
          flag_mismatch($sformatf("frame_count read %0d, holds %0d",
                                  prdata[FC_W-1:0], fc_reg));
        end
      end
      if (start && !busy && insert_sample(sample, med))
        pending_medians = {pending_medians, med};
    end
    mismatches      <= err_count;
    pending         <= pending_medians.size();
    medians_checked <= done_count;
  end

endmodule

FILE: bench/multi_frame_pixel_median_tb.sv
`timescale 1ns / 1ps
module multi_frame_pixel_median_tb;
  import mfpm_pkg::*;

  localparam int SAMPLES_TARGET = 1550;
  localparam int STALL_LIMIT    = 1000;

  logic                clk     = 1'b0;
  logic                rst     = 1'b1;
  logic                start   = 1'b0;
  logic [SAMPLE_W-1:0] sample  = '0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic                busy;
  logic                valid;
  logic [SAMPLE_W-1:0] median_value;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int        mismatches;
  int        pending;
  int        medians_checked;
  int        samples_sent = 0;
  int        fc_writes    = 0;
  int        stall_cycles = 0;
  bit        idle_on      = 1'b1;
  logic [15:0] fc_seen    = '0;

  always #10 clk = ~clk;

  multi_frame_pixel_median dut (.*);

  mfpm_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || valid || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** multi_frame_pixel_median: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] v);
    if (idle_on && $urandom_range(99) < 19) begin
      start  <= 1'b0;
      sample <= SAMPLE_W'($urandom());
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start  <= 1'b1;
    sample <= v;
    do @(posedge clk); while (busy);
    samples_sent++;
  endtask

  // Hold the sender until every outstanding median has come out.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_transfer(input bit wr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_FRAME_COUNT, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Write frame_count with junk in the upper bits, then read it back.
  task automatic set_frame_count(input logic [FC_W-1:0] v);
    logic [DATA_W-1:0] word;
    word          = $urandom();
    word[FC_W-1:0] = v;
    apb_transfer(1'b1, word);
    apb_transfer(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    fc_writes++;
    fc_seen[v] = 1'b1;
  endtask

  initial begin
    logic [FC_W-1:0]     fcv;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] v;
    int                  frames;
    int                  positions;
    int                  partial;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // frame_count of 1 after reset: every sample is its own median
    push_sample(8'h00);
    push_sample(8'hFF);
    push_sample(8'h55);
    push_sample(8'hAA);
    settle();
    set_frame_count(4'd0);
    push_sample(8'h80);
    push_sample(8'h01);
    settle();
    set_frame_count(4'd3);
    push_sample(8'd200);
    push_sample(8'd10);
    push_sample(8'd100);
    settle();
    set_frame_count(4'd2);
    push_sample(8'd7);
    push_sample(8'd3);
    // above the maximum: saturate, with repeated values in the row
    settle();
    set_frame_count(4'd15);
    push_sample(8'd5);
    push_sample(8'd5);
    push_sample(8'd250);
    push_sample(8'd0);
    push_sample(8'd5);
    push_sample(8'd255);
    push_sample(8'd1);
    push_sample(8'd5);
    // abandon a half-gathered position with a rewrite
    settle();
    set_frame_count(4'd4);
    push_sample(8'd9);
    push_sample(8'd2);
    settle();
    set_frame_count(4'd4);
    push_sample(8'd9);
    push_sample(8'd2);
    push_sample(8'd9);
    push_sample(8'd2);

    while (samples_sent < SAMPLES_TARGET) begin
      idle_on = !(samples_sent >= 500 && samples_sent < 850);
      case ($urandom_range(9))
        0:       fcv = '0;
        1:       fcv = FC_W'($urandom_range(MAX_FRAMES + 1, 15));
        2:       fcv = FC_W'(MAX_FRAMES);
        3:       fcv = FC_W'(1);
        default: fcv = FC_W'($urandom_range(1, MAX_FRAMES));
      endcase
      settle();
      set_frame_count(fcv);
      frames = (fcv == 0) ? 1 : ((fcv > MAX_FRAMES) ? MAX_FRAMES : fcv);
      positions = $urandom_range(3, 12);
      for (int p = 0; p < positions; p++) begin
        base = SAMPLE_W'($urandom());
        for (int k = 0; k < frames; k++) begin
          case ($urandom_range(7))
            0:       v = '0;
            1:       v = '1;
            2, 3:    v = base ^ SAMPLE_W'($urandom_range(1));
            default: v = SAMPLE_W'($urandom());
          endcase
          push_sample(v);
        end
      end
      // leave a position open now and then; the next write discards it
      if (frames > 1 && $urandom_range(3) == 0) begin
        partial = $urandom_range(1, frames - 1);
        for (int k = 0; k < partial; k++) push_sample(SAMPLE_W'($urandom()));
      end
    end
    settle();

    $display("covered %0d samples, %0d medians checked, %0d frame_count writes",
             samples_sent, medians_checked, fc_writes);
    $display("frame_count values written (bit per value): %b", fc_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("** multi_frame_pixel_median: PASSED **");
    end else begin
      $display("** multi_frame_pixel_median: FAILED **");
    end
    $finish;
  end

endmodule
